FILE: src/cp2u8_pkg.sv
// Shared types, constants and the high control code table of the CP1252 to UTF-8 transcoder.
`timescale 1ns / 1ps

package cp2u8_pkg;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  localparam logic [15:0] CpSpace = 16'h0020;
  localparam logic [7:0]  ByteZero = 8'h00;

  // Number of UTF-8 bytes in a command; NB_NONE marks an end marker only.
  localparam logic [1:0] NB_NONE  = 2'd0;
  localparam logic [1:0] NB_ONE   = 2'd1;
  localparam logic [1:0] NB_TWO   = 2'd2;
  localparam logic [1:0] NB_THREE = 2'd3;

  // One queued piece of work: up to three encoded bytes, first byte in slot 0.
  typedef struct packed {
    logic [2:0][7:0] data;
    logic [1:0]      nbytes;
    logic            eos;
  } cmd_t;

  // Code point of a byte in the 0x80..0x9F range, indexed by its low five bits.
  function automatic logic [15:0] high_ctrl_cp(input logic [4:0] idx);
    logic [15:0] cp;
    unique case (idx)
      5'h00: cp = 16'h20AC;
      5'h01: cp = CpSpace;
      5'h02: cp = 16'h201A;
      5'h03: cp = 16'h0192;
      5'h04: cp = 16'h201E;
      5'h05: cp = 16'h2026;
      5'h06: cp = 16'h2020;
      5'h07: cp = 16'h2021;
      5'h08: cp = 16'h02C6;
      5'h09: cp = 16'h2030;
      5'h0A: cp = 16'h0160;
      5'h0B: cp = 16'h2039;
      5'h0C: cp = 16'h0152;
      5'h0D: cp = CpSpace;
      5'h0E: cp = 16'h017D;
      5'h0F: cp = CpSpace;
      5'h10: cp = CpSpace;
      5'h11: cp = 16'h2018;
      5'h12: cp = 16'h2019;
      5'h13: cp = 16'h201C;
      5'h14: cp = 16'h201D;
      5'h15: cp = 16'h2022;
      5'h16: cp = 16'h2013;
      5'h17: cp = 16'h2014;
      5'h18: cp = 16'h02DC;
      5'h19: cp = 16'h2122;
      5'h1A: cp = 16'h0161;
      5'h1B: cp = 16'h203A;
      5'h1C: cp = 16'h0153;
      5'h1D: cp = CpSpace;
      5'h1E: cp = 16'h017E;
      5'h1F: cp = 16'h0178;
      default: cp = CpSpace;
    endcase
    return cp;
  endfunction

endpackage

FILE: src/cp2u8_if.sv
// Valid/ready channel interfaces for the input bytes and the UTF-8 result bytes.
`timescale 1ns / 1ps

interface cp2u8_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_string;

  modport source (output valid, output in_byte, output end_of_string, input ready);
  modport sink   (input valid, input in_byte, input end_of_string, output ready);
endinterface

interface cp2u8_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       last_of_run;
  logic       string_done;

  modport source (output valid, output out_byte, output byte_valid, output last_of_run,
                  output string_done, input ready);
  modport sink   (input valid, input out_byte, input byte_valid, input last_of_run,
                  input string_done, output ready);
endinterface

FILE: src/cp2u8_front.sv
// Front end: accepts input bytes, tracks string termination and encodes code points.
`timescale 1ns / 1ps

module cp2u8_front import cp2u8_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       end_of_string_i,
  input  logic       q_full_i,
  output logic       q_push_o,
  output cmd_t       q_cmd_o
);

  logic        terminated_q, terminated_d;
  logic        accept;
  logic        is_zero;
  logic        emits;
  logic [15:0] cp;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign is_zero    = (in_byte_i == ByteZero);
  assign emits      = !terminated_q && !is_zero;

  always_comb begin
    if (in_byte_i[7:5] == 3'b100) begin
      cp = high_ctrl_cp(in_byte_i[4:0]);
    end else begin
      cp = {8'h00, in_byte_i};
    end
  end

  always_comb begin
    q_cmd_o.eos  = end_of_string_i;
    q_cmd_o.data = '0;
    if (!emits) begin
      q_cmd_o.nbytes = NB_NONE;
    end else if (cp[15:7] == '0) begin
      q_cmd_o.nbytes  = NB_ONE;
      q_cmd_o.data[0] = cp[7:0];
    end else if (cp[15:11] == '0) begin
      q_cmd_o.nbytes  = NB_TWO;
      q_cmd_o.data[0] = {3'b110, cp[10:6]};
      q_cmd_o.data[1] = {2'b10, cp[5:0]};
    end else begin
      q_cmd_o.nbytes  = NB_THREE;
      q_cmd_o.data[0] = {4'b1110, cp[15:12]};
      q_cmd_o.data[1] = {2'b10, cp[11:6]};
      q_cmd_o.data[2] = {2'b10, cp[5:0]};
    end
  end

  // Drop items that give neither a byte nor an end marker.
  assign q_push_o = accept && (emits || end_of_string_i);

  always_comb begin
    terminated_d = terminated_q;
    if (accept) begin
      if (end_of_string_i) begin
        terminated_d = 1'b0;
      end else if (!terminated_q && is_zero) begin
        terminated_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      terminated_q <= 1'b0;
    end else begin
      terminated_q <= terminated_d;
    end
  end

endmodule

FILE: src/cp2u8_queue.sv
// Short command queue between the front end and the byte emitter.
`timescale 1ns / 1ps

module cp2u8_queue import cp2u8_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic head_valid_o,
  output cmd_t head_o
);

  cmd_t                 mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QueueCntW-1:0] count_q;

  assign full_o       = (count_q == QueueCntW'(QueueDepth));
  assign head_valid_o = (count_q != '0);
  assign head_o       = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

FILE: src/cp2u8_back.sv
// Back end: one queued UTF-8 byte per cycle unless stalled, via an output register.
`timescale 1ns / 1ps

module cp2u8_back import cp2u8_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       head_valid_i,
  input  cmd_t       head_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       byte_valid_o,
  output logic       last_of_run_o,
  output logic       string_done_o
);

  logic [1:0] idx_q, idx_d;
  logic       out_valid_q, out_valid_d;
  logic [7:0] byte_q;
  logic       bvalid_q, last_q, done_q;
  logic       load;
  logic       is_last;
  logic [7:0] sel_byte;

  assign load    = head_valid_i && (!out_valid_q || out_ready_i);
  assign is_last = (head_i.nbytes == NB_NONE) || (idx_q == head_i.nbytes - 2'd1);
  assign pop_o   = load && is_last;

  always_comb begin
    unique case (idx_q)
      2'd0:    sel_byte = head_i.data[0];
      2'd1:    sel_byte = head_i.data[1];
      2'd2:    sel_byte = head_i.data[2];
      default: sel_byte = ByteZero;
    endcase
  end

  always_comb begin
    idx_d = idx_q;
    if (pop_o) begin
      idx_d = '0;
    end else if (load) begin
      idx_d = idx_q + 2'd1;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q   <= sel_byte;
      bvalid_q <= (head_i.nbytes != NB_NONE);
      last_q   <= is_last;
      done_q   <= is_last && head_i.eos;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_byte_o    = byte_q;
  assign byte_valid_o  = bvalid_q;
  assign last_of_run_o = last_q;
  assign string_done_o = done_q;

endmodule

FILE: src/cp1252_to_utf8_transcoder.sv
// Top level of the CP1252 to UTF-8 transcoder.
//
// Channels: in_ch_i takes one CP1252 byte per item with an end_of_string flag;
// out_ch_o gives one UTF-8 byte per item with byte_valid, last_of_run and
// string_done. Both use valid/ready; an item moves when both are high.
// Structure: the front end accepts and encodes each byte into a command of
// one to three bytes (or an end marker) and pushes it into a two-entry queue;
// the back end drains it one output byte per cycle, unless out_ch_o stalls,
// into a registered output stage. Bytes after a string's zero terminator, and
// the terminator itself, push nothing unless they carry end_of_string.
// Path: an accepted item is written into the queue, waits at the queue head
// until the output stage is free, is then loaded into the registered output
// stage, and its first result can be taken from there.
// Throughput: the output port sets the rate, one byte per cycle while ready;
// an item gives one to three results by UTF-8 length (one for an end marker,
// none for a dropped byte). Input is taken whenever the queue has a free entry.
// Reset: clears the terminated flag, the queue and the output stage; no
// results are pending afterwards.
// Stall: when out_ch_o is not ready the output holds, the queue fills, and
// then in_ch_i drops ready until the receiver takes an item.
`timescale 1ns / 1ps

module cp1252_to_utf8_transcoder import cp2u8_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  cp2u8_in_if.sink    in_ch_i,
  cp2u8_out_if.source out_ch_o
);

  logic q_push, q_full, q_pop, q_head_valid;
  cmd_t q_cmd, q_head;

  // Accept, classify and encode.
  cp2u8_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_ch_i.valid),
    .in_ready_o      (in_ch_i.ready),
    .in_byte_i       (in_ch_i.in_byte),
    .end_of_string_i (in_ch_i.end_of_string),
    .q_full_i        (q_full),
    .q_push_o        (q_push),
    .q_cmd_o         (q_cmd)
  );

  // Decouple the two sides.
  cp2u8_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (q_push),
    .cmd_i        (q_cmd),
    .full_o       (q_full),
    .pop_i        (q_pop),
    .head_valid_o (q_head_valid),
    .head_o       (q_head)
  );

  // Serialize the encoded bytes.
  cp2u8_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_valid_i  (q_head_valid),
    .head_i        (q_head),
    .pop_o         (q_pop),
    .out_valid_o   (out_ch_o.valid),
    .out_ready_i   (out_ch_o.ready),
    .out_byte_o    (out_ch_o.out_byte),
    .byte_valid_o  (out_ch_o.byte_valid),
    .last_of_run_o (out_ch_o.last_of_run),
    .string_done_o (out_ch_o.string_done)
  );

endmodule

FILE: src/cp2u8_checker.sv
// Port-level assertions for the transcoder, bound to the top level.
`timescale 1ns / 1ps

module cp2u8_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_byte_i,
  input logic       byte_valid_i,
  input logic       last_of_run_i,
  input logic       string_done_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> out_valid_i)
    else $error("output item dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> $stable(out_byte_i))
    else $error("output byte changed while stalled");

  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && string_done_i) |-> last_of_run_i)
    else $error("string_done without last_of_run");

  a_marker_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !byte_valid_i) |->
      (last_of_run_i && string_done_i && out_byte_i == 8'h00))
    else $error("malformed end marker");

endmodule

bind cp1252_to_utf8_transcoder cp2u8_checker u_cp2u8_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_ch_o.valid),
  .out_ready_i   (out_ch_o.ready),
  .out_byte_i    (out_ch_o.out_byte),
  .byte_valid_i  (out_ch_o.byte_valid),
  .last_of_run_i (out_ch_o.last_of_run),
  .string_done_i (out_ch_o.string_done)
);

FILE: test/tb_cp1252_to_utf8_transcoder.sv
// Self-checking testbench of the CP1252 to UTF-8 transcoder with a built-in encoder model.
`timescale 1ns / 1ps

module tb_cp1252_to_utf8_transcoder;

  localparam logic [7:0] NulByte  = 8'h00;
  localparam int         MaxShown = 10;

  // One expected UTF-8 result item.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       last_of_run;
    logic       string_done;
  } utf8_res_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  cp2u8_in_if  in_ch ();
  cp2u8_out_if out_ch ();

  cp1252_to_utf8_transcoder i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_ch_i (in_ch),
    .out_ch_o(out_ch)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Encoder model state and the results it still expects, oldest first.
  logic      zero_seen = 1'b0;
  utf8_res_t utf8_expected[$];
  int        mismatch_count = 0;
  logic      idle_on = 1'b1;
  int        stall_left = 0;

  // Code point of a byte in the 0x80..0x9F block; undefined codes give space.
  function automatic logic [15:0] win_high_cp(input logic [4:0] idx);
    case (idx)
      5'd0:  return 16'h20AC;
      5'd2:  return 16'h201A;
      5'd3:  return 16'h0192;
      5'd4:  return 16'h201E;
      5'd5:  return 16'h2026;
      5'd6:  return 16'h2020;
      5'd7:  return 16'h2021;
      5'd8:  return 16'h02C6;
      5'd9:  return 16'h2030;
      5'd10: return 16'h0160;
      5'd11: return 16'h2039;
      5'd12: return 16'h0152;
      5'd14: return 16'h017D;
      5'd17: return 16'h2018;
      5'd18: return 16'h2019;
      5'd19: return 16'h201C;
      5'd20: return 16'h201D;
      5'd21: return 16'h2022;
      5'd22: return 16'h2013;
      5'd23: return 16'h2014;
      5'd24: return 16'h02DC;
      5'd25: return 16'h2122;
      5'd26: return 16'h0161;
      5'd27: return 16'h203A;
      5'd28: return 16'h0153;
      5'd30: return 16'h017E;
      5'd31: return 16'h0178;
      default: return 16'h0020;
    endcase
  endfunction

  // Encode one accepted input item and queue the UTF-8 bytes it must produce.
  task automatic encode_cp1252(input logic [7:0] b, input logic eos);
    logic [15:0] cp;
    logic [7:0]  enc[3];
    int          n;
    n = 0;
    if (!zero_seen) begin
      if (b == NulByte) begin
        zero_seen = 1'b1;
      end else begin
        cp = (b[7:5] == 3'b100) ? win_high_cp(b[4:0]) : {8'h00, b};
        if (cp < 16'h0080) begin
          enc[0] = cp[7:0];
          n = 1;
        end else if (cp < 16'h0800) begin
          enc[0] = {3'b110, cp[10:6]};
          enc[1] = {2'b10, cp[5:0]};
          n = 2;
        end else begin
          enc[0] = {4'b1110, cp[15:12]};
          enc[1] = {2'b10, cp[11:6]};
          enc[2] = {2'b10, cp[5:0]};
          n = 3;
        end
      end
    end
    for (int i = 0; i < n; i++) begin
      utf8_expected.push_back('{enc[i], 1'b1, i == n - 1, (i == n - 1) && eos});
    end
    if (eos) begin
      // End of string with nothing to show: emit a bare end marker.
      if (n == 0) utf8_expected.push_back('{NulByte, 1'b0, 1'b1, 1'b1});
      zero_seen = 1'b0;
    end
  endtask

  task automatic note_mismatch(input string what, input utf8_res_t want, input utf8_res_t got);
    mismatch_count++;
    if (mismatch_count <= MaxShown) begin
      $display("%0t: %s: expected byte %h bv %b last %b done %b, got byte %h bv %b last %b done %b",
               $realtime, what, want.out_byte, want.byte_valid, want.last_of_run,
               want.string_done, got.out_byte, got.byte_valid, got.last_of_run,
               got.string_done);
    end
  endtask

  // Check each result item against the oldest expectation, then model each input item.
  always @(posedge clk_i) begin
    utf8_res_t got;
    utf8_res_t want;
    if (rst_ni) begin
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.out_byte, out_ch.byte_valid, out_ch.last_of_run, out_ch.string_done};
        if (utf8_expected.size() == 0) begin
          note_mismatch("unexpected result", '0, got);
        end else begin
          want = utf8_expected.pop_front();
          if (got !== want) note_mismatch("result mismatch", want, got);
        end
      end
      if (in_ch.valid && in_ch.ready) encode_cp1252(in_ch.in_byte, in_ch.end_of_string);
    end
  end

  // Receiver: stall in random bursts while idling is enabled.
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      out_ch.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      out_ch.ready <= 1'b0;
      stall_left   <= $urandom_range(0, 3);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Send one item; hold it until the block takes it. Returns at the accepting edge.
  task automatic send_item(input logic [7:0] b, input logic eos);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_ch.valid         <= 1'b1;
    in_ch.in_byte       <= b;
    in_ch.end_of_string <= eos;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  // Mostly printable and mapped bytes, with some fully random noise.
  function automatic logic [7:0] pick_text_byte();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 8'($urandom_range(8'h01, 8'h7F));
      4, 5, 6:    return 8'($urandom_range(8'h80, 8'h9F));
      7, 8:       return 8'($urandom_range(8'hA0, 8'hFF));
      default:    return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Send one random string; return how many of its items the block acts on.
  task automatic send_random_string(output int live);
    int   len;
    int   nul_at;
    logic hit_nul;
    logic [7:0] b;
    len     = $urandom_range(1, 10);
    nul_at  = ($urandom_range(0, 7) == 0) ? $urandom_range(0, len - 1) : -1;
    hit_nul = 1'b0;
    live    = 0;
    for (int i = 0; i < len; i++) begin
      b = (i == nul_at) ? NulByte : pick_text_byte();
      if (b == NulByte) hit_nul = 1'b1;
      // The terminator and the bytes past it push nothing and do not count; the end item does.
      if (!hit_nul || i == len - 1) live++;
      send_item(b, i == len - 1);
    end
  endtask

  task automatic test_single_byte_ranges();
    send_item(8'h01, 1'b0);
    send_item(8'h7F, 1'b0);
    send_item(8'hA0, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'h41, 1'b1);
    send_item(8'hFF, 1'b1);
  endtask

  task automatic test_high_control_table();
    send_item(8'h80, 1'b0);   // euro sign, three bytes
    send_item(8'h81, 1'b0);   // undefined code, maps to space
    send_item(8'h8A, 1'b0);   // two-byte code point
    send_item(8'h9D, 1'b0);
    send_item(8'h9F, 1'b0);
    send_item(8'h99, 1'b1);   // three bytes with the string done flag
  endtask

  task automatic test_terminator();
    send_item(8'h41, 1'b0);
    send_item(NulByte, 1'b0); // terminator: nothing from here on
    send_item(8'h42, 1'b0);
    send_item(8'h80, 1'b1);   // dropped byte at the end: bare marker
    send_item(8'h43, 1'b1);   // new string starts clean
  endtask

  task automatic test_end_marker();
    send_item(NulByte, 1'b1); // terminator that also ends the string
    send_item(NulByte, 1'b0);
    send_item(NulByte, 1'b1);
    send_item(8'hC9, 1'b0);
    send_item(8'h8C, 1'b1);
  endtask

  task automatic test_random_strings(input int target);
    int done_items;
    int live;
    done_items = 0;
    while (done_items < target) begin
      send_random_string(live);
      done_items += live;
    end
  endtask

  task automatic test_back_to_back(input int target);
    idle_on <= 1'b0;
    test_random_strings(target);
  endtask

  initial begin
    in_ch.valid         <= 1'b0;
    in_ch.in_byte       <= NulByte;
    in_ch.end_of_string <= 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_single_byte_ranges();
    test_high_control_table();
    test_terminator();
    test_end_marker();
    test_random_strings(330);
    test_back_to_back(80);

    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (utf8_expected.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    if (mismatch_count == 0 && utf8_expected.size() == 0) begin
      $display("[cp1252_to_utf8_transcoder] OK");
    end else begin
      $display("[cp1252_to_utf8_transcoder] ERROR");
    end
    $finish;
  end

  // Watchdog: a healthy run needs well under a tenth of this.
  initial begin
    #2_000_000;
    $display("[cp1252_to_utf8_transcoder] ERROR");
    $finish;
  end

endmodule
